// ===== src/cpr_pkg.sv =====
// Shared types and constants for the clock page replacement queue.
// No dependencies.
package cpr_pkg;

  localparam int CPR_SLOTS = 8;
  localparam int MODE_W    = 3;
  localparam int PAGE_W    = 20;
  localparam int SLOT_W    = 3;

  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TOUCH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_EVICT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_REM_TAIL,
    ST_DONE
  } cpr_state_t;

  typedef struct packed {
    logic hit;
    logic empty;
    logic evictable;
  } cpr_probe_t;

endpackage

// ===== src/cpr_if.sv =====
// Request and response channel interfaces for the clock page replacement queue.
// Depends on cpr_pkg.
interface cpr_req_if;
  import cpr_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PAGE_W-1:0]   page_number;
  modport source (output valid, output mode, output page_number, input ready);
  modport sink (input valid, input mode, input page_number, output ready);
endinterface

interface cpr_rsp_if;
  import cpr_pkg::*;
  logic                valid;
  logic                ready;
  logic                status;
  logic                evicted_valid;
  logic [PAGE_W-1:0]   evicted_page;
  logic [SLOT_W-1:0]   slot_index;
  modport source (output valid, output status, output evicted_valid, output evicted_page,
                  output slot_index, input ready);
  modport sink (input valid, input status, input evicted_valid, input evicted_page,
                input slot_index, output ready);
endinterface

// ===== src/cpr_page_ram.sv =====
// Page number store: one write port, one read port with registered read data.
// Depends on cpr_pkg.
module cpr_page_ram #(
  parameter int DEPTH = cpr_pkg::CPR_SLOTS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [cpr_pkg::PAGE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [cpr_pkg::PAGE_W-1:0] rdata
);
  import cpr_pkg::*;

  logic [PAGE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cpr_slot_cmp.sv =====
// Shared slot probe: page match and replacement decision for the slot under the cursor.
// Depends on cpr_pkg.
module cpr_slot_cmp (
  input  logic                       slot_valid,
  input  logic                       slot_ref,
  input  logic [cpr_pkg::PAGE_W-1:0] slot_page,
  input  logic [cpr_pkg::PAGE_W-1:0] key,
  output cpr_pkg::cpr_probe_t        probe
);
  import cpr_pkg::*;

  always_comb begin
    probe.hit       = slot_valid && (slot_page == key);
    probe.empty     = !slot_valid;
    probe.evictable = slot_valid && !slot_ref;
  end

endmodule

// ===== src/clock_page_replacement_queue_top.sv =====
// Clock (second-chance) page replacement queue: sequencer, slot flags and result register.
// Depends on cpr_pkg, cpr_if, cpr_page_ram, cpr_slot_cmp.
// One operation at a time, one slot probed per step of the sequencer. Insert sweeps at
// most SLOTS+1 slots from the one after the hand, giving referenced slots a second chance.
// Remove, touch and search read the page store and then compare, slot by slot; remove
// also shifts each following entry down with a read and a write and empties the tail
// slot. The single-port page store read sets the scan pace. A finished result waits in
// the output register while the next beat is accepted.
module clock_page_replacement_queue_top #(
  parameter int SLOTS = cpr_pkg::CPR_SLOTS
) (
  input  logic      clk,
  input  logic      rst,
  cpr_req_if.sink   req,
  cpr_rsp_if.source rsp
);
  import cpr_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  cpr_state_t state, state_next;

  logic [IW-1:0]     hand, hand_next;
  logic [IW-1:0]     cur, cur_next;
  logic [IW-1:0]     cnt, cnt_next;
  logic [MODE_W-1:0] op, op_next;
  logic [PAGE_W-1:0] key, key_next;
  logic [SLOTS-1:0]  slot_valid, slot_valid_next;
  logic [SLOTS-1:0]  slot_ref, slot_ref_next;

  logic              res_status, res_status_next;
  logic              res_ev_valid, res_ev_valid_next;
  logic [PAGE_W-1:0] res_ev_page, res_ev_page_next;
  logic [IW-1:0]     res_slot, res_slot_next;

  logic              out_valid, out_valid_next;
  logic              out_status, out_status_next;
  logic              out_ev_valid, out_ev_valid_next;
  logic [PAGE_W-1:0] out_ev_page, out_ev_page_next;
  logic [SLOT_W-1:0] out_slot, out_slot_next;

  logic              req_ready;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [PAGE_W-1:0] ram_wdata, ram_rdata;
  logic [IW-1:0]     cur_inc, hand_dec;
  cpr_probe_t        probe;

  cpr_page_ram #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cpr_slot_cmp u_cmp (
    .slot_valid (slot_valid[cur]),
    .slot_ref   (slot_ref[cur]),
    .slot_page  (ram_rdata),
    .key        (key),
    .probe      (probe)
  );

  assign cur_inc  = (cur == LAST) ? '0 : cur + 1'b1;
  assign hand_dec = (hand == '0) ? LAST : hand - 1'b1;

  assign req.ready         = req_ready;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.evicted_valid = out_ev_valid;
  assign rsp.evicted_page  = out_ev_page;
  assign rsp.slot_index    = out_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hand       <= LAST;
      slot_valid <= '0;
      slot_ref   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      hand       <= hand_next;
      slot_valid <= slot_valid_next;
      slot_ref   <= slot_ref_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur          <= cur_next;
    cnt          <= cnt_next;
    op           <= op_next;
    key          <= key_next;
    res_status   <= res_status_next;
    res_ev_valid <= res_ev_valid_next;
    res_ev_page  <= res_ev_page_next;
    res_slot     <= res_slot_next;
    out_status   <= out_status_next;
    out_ev_valid <= out_ev_valid_next;
    out_ev_page  <= out_ev_page_next;
    out_slot     <= out_slot_next;
  end

  always_comb begin
    state_next        = state;
    hand_next         = hand;
    cur_next          = cur;
    cnt_next          = cnt;
    op_next           = op;
    key_next          = key;
    slot_valid_next   = slot_valid;
    slot_ref_next     = slot_ref;
    res_status_next   = res_status;
    res_ev_valid_next = res_ev_valid;
    res_ev_page_next  = res_ev_page;
    res_slot_next     = res_slot;
    out_valid_next    = out_valid && !rsp.ready;
    out_status_next   = out_status;
    out_ev_valid_next = out_ev_valid;
    out_ev_page_next  = out_ev_page;
    out_slot_next     = out_slot;
    req_ready         = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = cur;
    ram_wdata         = key;
    ram_raddr         = cur;

    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          op_next           = req.mode;
          key_next          = req.page_number;
          cnt_next          = '0;
          res_status_next   = 1'b0;
          res_ev_valid_next = 1'b0;
          res_ev_page_next  = '0;
          res_slot_next     = '0;
          case (req.mode)
            MODE_INSERT: begin
              cur_next   = (hand == LAST) ? '0 : hand + 1'b1;
              state_next = ST_INS_CHK;
            end
            MODE_REMOVE: begin
              cur_next   = hand;
              state_next = ST_SCAN_RD;
            end
            MODE_TOUCH, MODE_SEARCH: begin
              cur_next   = '0;
              state_next = ST_SCAN_RD;
            end
            MODE_CLEAR: begin
              slot_valid_next = '0;
              slot_ref_next   = '0;
              hand_next       = LAST;
              state_next      = ST_DONE;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_INS_CHK: begin
        if (probe.empty) begin
          ram_we               = 1'b1;
          slot_valid_next[cur] = 1'b1;
          slot_ref_next[cur]   = 1'b0;
          hand_next            = cur;
          res_slot_next        = cur;
          state_next           = ST_DONE;
        end else if (probe.evictable) begin
          state_next = ST_INS_EVICT;
        end else begin
          // second chance
          slot_ref_next[cur] = 1'b0;
          cur_next           = cur_inc;
        end
      end
      ST_INS_EVICT: begin
        ram_we             = 1'b1;
        slot_ref_next[cur] = 1'b0;
        hand_next          = cur;
        res_ev_valid_next  = 1'b1;
        res_ev_page_next   = ram_rdata;
        res_slot_next      = cur;
        state_next         = ST_DONE;
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (probe.hit) begin
          case (op)
            MODE_REMOVE: begin
              state_next = (cur == hand) ? ST_REM_TAIL : ST_SHIFT_RD;
            end
            MODE_TOUCH: begin
              slot_ref_next[cur] = 1'b1;
              state_next         = ST_DONE;
            end
            default: begin
              res_slot_next = cur;
              state_next    = ST_DONE;
            end
          endcase
        end else if (cnt == LAST) begin
          res_status_next = 1'b1;
          state_next      = ST_DONE;
        end else begin
          cnt_next   = cnt + 1'b1;
          cur_next   = cur_inc;
          state_next = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        ram_raddr  = cur_inc;
        state_next = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        ram_we               = 1'b1;
        ram_wdata            = ram_rdata;
        slot_valid_next[cur] = slot_valid[cur_inc];
        slot_ref_next[cur]   = slot_ref[cur_inc];
        cur_next             = cur_inc;
        state_next           = (cur_inc == hand) ? ST_REM_TAIL : ST_SHIFT_RD;
      end
      ST_REM_TAIL: begin
        slot_valid_next[hand] = 1'b0;
        slot_ref_next[hand]   = 1'b0;
        hand_next             = hand_dec;
        state_next            = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next    = 1'b1;
          out_status_next   = res_status;
          out_ev_valid_next = res_ev_valid;
          out_ev_page_next  = res_ev_page;
          out_slot_next     = SLOT_W'(res_slot);
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_hand_range: assert property (@(posedge clk) disable iff (rst) hand <= LAST)
    else $error("clock hand beyond last slot");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status |->
      !rsp.evicted_valid && rsp.evicted_page == '0 && rsp.slot_index == '0)
    else $error("not-found beat carries nonzero fields");

  a_beat_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_DONE))
    else $error("response beat raised outside completion");
`endif

endmodule

// ===== test/tb_top.sv =====
// Testbench for clock_page_replacement_queue_top: directed table, then random page traffic.
// Results are checked against an in-bench clock-ring predictor.
// Depends on cpr_pkg, cpr_if and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_MISS = 1'b1;

  localparam int RAND_OPS    = 1025;
  localparam int POOL_N      = 10;
  localparam int DRAIN_CYC   = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DIR_N       = 25;

  typedef struct packed {
    logic              status;
    logic              ev_valid;
    logic [PAGE_W-1:0] ev_page;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PAGE_W-1:0] page;
    logic              fixed;
    rsp_t              want;
  } op_t;

  localparam rsp_t R_ZERO = '{STAT_OK, 1'b0, 20'h00000, 3'd0};
  localparam rsp_t R_MISS = '{STAT_MISS, 1'b0, 20'h00000, 3'd0};
  localparam rsp_t R_S1   = '{STAT_OK, 1'b0, 20'h00000, 3'd1};
  localparam rsp_t R_S2   = '{STAT_OK, 1'b0, 20'h00000, 3'd2};

  // fixed = 1 rows carry a typed result; the rest go through the predictor
  localparam op_t DIR_TBL [DIR_N] = '{
    '{MODE_SEARCH,  20'h00000, 1'b1, R_MISS},
    '{MODE_REMOVE,  20'hFFFFF, 1'b1, R_MISS},
    '{MODE_TOUCH,   20'h00000, 1'b1, R_MISS},
    '{MODE_INSERT,  20'h00000, 1'b1, R_ZERO},
    '{MODE_INSERT,  20'hFFFFF, 1'b1, R_S1},
    '{MODE_INSERT,  20'h12345, 1'b1, R_S2},
    '{MODE_SEARCH,  20'hFFFFF, 1'b1, R_S1},
    '{MODE_TOUCH,   20'h00000, 1'b0, R_ZERO},
    '{MODE_INSERT,  20'h55555, 1'b0, R_ZERO},
    '{MODE_INSERT,  20'hAAAAA, 1'b0, R_ZERO},
    '{MODE_INSERT,  20'h0F0F0, 1'b0, R_ZERO},
    '{MODE_INSERT,  20'hF0F0F, 1'b0, R_ZERO},
    '{MODE_INSERT,  20'h00001, 1'b0, R_ZERO},
    '{MODE_TOUCH,   20'h55555, 1'b0, R_ZERO},
    '{MODE_INSERT,  20'h80000, 1'b0, R_ZERO},
    '{MODE_REMOVE,  20'h12345, 1'b0, R_ZERO},
    '{MODE_REMOVE,  20'h00001, 1'b0, R_ZERO},
    '{MODE_SEARCH,  20'h80000, 1'b0, R_ZERO},
    '{MODE_SPARE_A, 20'hFFFFF, 1'b1, R_ZERO},
    '{MODE_SPARE_B, 20'h00000, 1'b1, R_ZERO},
    '{MODE_SPARE_C, 20'h7FFFF, 1'b1, R_ZERO},
    '{MODE_CLEAR,   20'hFFFFF, 1'b1, R_ZERO},
    '{MODE_SEARCH,  20'h00000, 1'b1, R_MISS},
    '{MODE_INSERT,  20'hFFFFF, 1'b1, R_ZERO},
    '{MODE_REMOVE,  20'hFFFFF, 1'b0, R_ZERO}
  };

  logic clk;
  logic rst;

  cpr_req_if req_ch ();
  cpr_rsp_if rsp_ch ();

  clock_page_replacement_queue_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor state
  logic              ring_vld [CPR_SLOTS];
  logic [PAGE_W-1:0] ring_pg  [CPR_SLOTS];
  logic              ring_ref [CPR_SLOTS];
  int                ring_hand;

  op_t  ops [$];
  rsp_t pending_rsp [$];
  int   acc_cnt = 0;
  int   fails = 0;
  int   cycle_cnt = 0;

  task automatic ring_clear();
    for (int i = 0; i < CPR_SLOTS; i++) begin
      ring_vld[i] = 1'b0;
      ring_pg[i]  = '0;
      ring_ref[i] = 1'b0;
    end
    ring_hand = CPR_SLOTS - 1;
  endtask

  task automatic predict_page_op(input logic [MODE_W-1:0] mode, input logic [PAGE_W-1:0] page,
                                 output rsp_t r);
    int  where;
    int  idx;
    int  nx;
    bit  found;
    r     = R_ZERO;
    where = 0;
    found = 1'b0;
    case (mode)
      MODE_INSERT: begin
        for (int i = 0; i < 2 * CPR_SLOTS + 1; i++) begin
          ring_hand = (ring_hand + 1) % CPR_SLOTS;
          if (!ring_vld[ring_hand]) begin
            break;
          end else if (!ring_ref[ring_hand]) begin
            r.ev_valid = 1'b1;
            r.ev_page  = ring_pg[ring_hand];
            break;
          end else begin
            ring_ref[ring_hand] = 1'b0;
          end
        end
        ring_vld[ring_hand] = 1'b1;
        ring_pg[ring_hand]  = page;
        ring_ref[ring_hand] = 1'b0;
        r.slot = SLOT_W'(ring_hand);
      end
      MODE_REMOVE: begin
        for (int i = 0; i < CPR_SLOTS; i++) begin
          idx = (ring_hand + i) % CPR_SLOTS;
          if (!found && ring_vld[idx] && ring_pg[idx] == page) begin
            where = idx;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = STAT_MISS;
        end else begin
          idx = where;
          while (idx != ring_hand) begin
            nx = (idx + 1) % CPR_SLOTS;
            ring_vld[idx] = ring_vld[nx];
            ring_pg[idx]  = ring_pg[nx];
            ring_ref[idx] = ring_ref[nx];
            idx = nx;
          end
          ring_vld[ring_hand] = 1'b0;
          ring_pg[ring_hand]  = '0;
          ring_ref[ring_hand] = 1'b0;
          ring_hand = (ring_hand == 0) ? CPR_SLOTS - 1 : ring_hand - 1;
        end
      end
      MODE_TOUCH, MODE_SEARCH: begin
        for (int i = 0; i < CPR_SLOTS; i++) begin
          if (!found && ring_vld[i] && ring_pg[i] == page) begin
            where = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = STAT_MISS;
        end else if (mode == MODE_TOUCH) begin
          ring_ref[where] = 1'b1;
        end else begin
          r.slot = SLOT_W'(where);
        end
      end
      MODE_CLEAR: begin
        ring_clear();
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_beat(input rsp_t want, input rsp_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      fails++;
    end
    if (got.ev_valid !== want.ev_valid) begin
      $error("evicted_valid: expected %0d, actual %0d", want.ev_valid, got.ev_valid);
      fails++;
    end
    if (got.ev_page !== want.ev_page) begin
      $error("evicted_page: expected %05h, actual %05h", want.ev_page, got.ev_page);
      fails++;
    end
    if (got.slot !== want.slot) begin
      $error("slot_index: expected %0d, actual %0d", want.slot, got.slot);
      fails++;
    end
  endtask

  // random traffic over a small page pool so hits, evictions and misses all occur
  task automatic build_random_ops();
    logic [PAGE_W-1:0] pool [POOL_N];
    op_t o;
    int  made;
    int  r;
    int  k;
    made = 0;
    for (int i = 0; i < POOL_N; i++) pool[i] = PAGE_W'($urandom);
    while (made < RAND_OPS) begin
      r = $urandom_range(0, 99);
      o = '{MODE_INSERT, 20'h00000, 1'b0, R_ZERO};
      if (r < 6) begin
        for (int i = 0; i < POOL_N; i++) begin
          k = $urandom_range(0, 19);
          pool[i] = (k == 0) ? 20'h00000 : (k == 1) ? 20'hFFFFF : PAGE_W'($urandom);
        end
      end else if (r < 11) begin
        // second-chance sweep: reference everything, then insert
        for (int i = 0; i < POOL_N; i++) begin
          o.mode = MODE_TOUCH;
          o.page = pool[i];
          ops.push_back(o);
        end
        o.mode = MODE_INSERT;
        o.page = pool[$urandom_range(0, POOL_N - 1)];
        ops.push_back(o);
        made += POOL_N + 1;
      end else if (r < 14) begin
        o.mode = MODE_CLEAR;
        o.page = PAGE_W'($urandom);
        ops.push_back(o);
        made++;
      end else if (r < 18) begin
        o.mode = MODE_SPARE_A + MODE_W'($urandom_range(0, 2));
        o.page = PAGE_W'($urandom);
        ops.push_back(o);
        made++;
      end else begin
        k = $urandom_range(0, 99);
        o.mode = (k < 40) ? MODE_INSERT : (k < 60) ? MODE_TOUCH :
                 (k < 80) ? MODE_SEARCH : MODE_REMOVE;
        o.page = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_N - 1)]
                                                : PAGE_W'($urandom);
        ops.push_back(o);
        made++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall pattern: randomly chosen styles, each held for a random length
  initial begin
    int style;
    int style_left;
    int tick;
    style_left = 0;
    style = 0;
    tick = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 200);
      end
      style_left--;
      tick++;
      case (style)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= (tick % 6) < 2;
        default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // beat monitor, predictor and checker
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst) begin
      ring_clear();
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.status, rsp_ch.evicted_valid, rsp_ch.evicted_page, rsp_ch.slot_index};
        if (pending_rsp.size() == 0) begin
          $error("result beat with no request pending");
          fails++;
        end else begin
          want = pending_rsp.pop_front();
          check_beat(want, got);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        predict_page_op(req_ch.mode, req_ch.page_number, want);
        if (ops[acc_cnt].fixed) want = ops[acc_cnt].want;
        pending_rsp.push_back(want);
        acc_cnt++;
      end
    end
  end

  initial begin
    int burst_left;
    int gap;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_INSERT;
    req_ch.page_number = '0;
    burst_left = 0;
    for (int i = 0; i < DIR_N; i++) ops.push_back(DIR_TBL[i]);
    build_random_ops();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (ops[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= ops[i].mode;
      req_ch.page_number <= ops[i].page;
      @(posedge clk);
      while (!req_ch.ready) @(posedge clk);
      burst_left--;
    end
    req_ch.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cpr_pkg.sv
src/cpr_if.sv
src/cpr_page_ram.sv
src/cpr_slot_cmp.sv
src/clock_page_replacement_queue_top.sv
test/tb_top.sv
